[design/pet_pkg.sv]
// Shared types and constants for the periodic event trigger.
`timescale 1ns / 1ps

package pet_pkg;

	localparam int NUM_IN     = 4;
	localparam int SAMPLE_W   = 16;
	localparam int DIM_W      = 3;
	localparam int GAIN_W     = 16;
	localparam int EPS_W      = 15;
	localparam int SKIP_W     = 16;
	localparam int COST_W     = 16;
	localparam int CNT_W      = 32;
	localparam int ENERGY_W   = 48;
	localparam int MAG_W      = 17;
	localparam int SUM_W      = 2 * MAG_W;
	localparam int PROD_W     = GAIN_W + MAG_W;
	localparam int ROOT_W     = 17;
	localparam int ENORM_W    = 19;
	localparam int SNORM_W    = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DIMENSION  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIGMA      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EPSILON    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_COST  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SEND_COST  = 3'd5;

	localparam logic [DIM_W-1:0]  DIMENSION_RST  = 3'd4;
	localparam logic [GAIN_W-1:0] SIGMA_RST      = 16'd6554;
	localparam logic [EPS_W-1:0]  EPSILON_RST    = 15'd41;
	localparam logic [SKIP_W-1:0] SKIP_LIMIT_RST = 16'd100;
	localparam logic [COST_W-1:0] TICK_COST_RST  = 16'd410;
	localparam logic [COST_W-1:0] SEND_COST_RST  = 16'd4096;

	typedef struct packed {
		logic [DIM_W-1:0]  dimension;
		logic [GAIN_W-1:0] sigma;
		logic [EPS_W-1:0]  epsilon;
		logic [SKIP_W-1:0] skip_limit;
		logic [COST_W-1:0] tick_cost;
		logic [COST_W-1:0] send_cost;
	} cfg_regs_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC_E,
		ST_ACC_X,
		ST_SQ_E,
		ST_SQ_X,
		ST_MUL,
		ST_DECIDE
	} pet_state_t;

endpackage

[design/pet_sample_if.sv]
// Sample channel: one state vector per item.
`timescale 1ns / 1ps

interface pet_sample_if;
	import pet_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_0;
	logic signed [SAMPLE_W-1:0] sample_1;
	logic signed [SAMPLE_W-1:0] sample_2;
	logic signed [SAMPLE_W-1:0] sample_3;

	modport source (output valid, sample_0, sample_1, sample_2, sample_3, input ready);
	modport sink (input valid, sample_0, sample_1, sample_2, sample_3, output ready);
endinterface

[design/pet_result_if.sv]
// Result channel: trigger decision, norms and running totals.
`timescale 1ns / 1ps

interface pet_result_if;
	import pet_pkg::*;

	logic                valid;
	logic                ready;
	logic                transmit;
	logic                forced;
	logic [ENORM_W-1:0]  error_norm;
	logic [SNORM_W-1:0]  state_norm;
	logic [SKIP_W-1:0]   skips;
	logic [CNT_W-1:0]    samples_seen;
	logic [CNT_W-1:0]    events_sent;
	logic [ENERGY_W-1:0] energy_used;

	modport source (output valid, transmit, forced, error_norm, state_norm, skips,
		samples_seen, events_sent, energy_used, input ready);
	modport sink (input valid, transmit, forced, error_norm, state_norm, skips,
		samples_seen, events_sent, energy_used, output ready);
endinterface

[design/pet_cfg_if.sv]
// Configuration write channel.
`timescale 1ns / 1ps

interface pet_cfg_if;
	import pet_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[design/pet_cfg.sv]
// Configuration register file.
`timescale 1ns / 1ps

module pet_cfg (
	input  logic              clk,
	input  logic              arst_n,
	pet_cfg_if.sink           cfg,
	output pet_pkg::cfg_regs_t regs
);
	import pet_pkg::*;

	cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '{dimension: DIMENSION_RST, sigma: SIGMA_RST, epsilon: EPSILON_RST,
				skip_limit: SKIP_LIMIT_RST, tick_cost: TICK_COST_RST,
				send_cost: SEND_COST_RST};
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DIMENSION:  regs_q.dimension  <= cfg.data[DIM_W-1:0];
				REG_SIGMA:      regs_q.sigma      <= cfg.data[GAIN_W-1:0];
				REG_EPSILON:    regs_q.epsilon    <= cfg.data[EPS_W-1:0];
				REG_SKIP_LIMIT: regs_q.skip_limit <= cfg.data[SKIP_W-1:0];
				REG_TICK_COST:  regs_q.tick_cost  <= cfg.data[COST_W-1:0];
				REG_SEND_COST:  regs_q.send_cost  <= cfg.data[COST_W-1:0];
				default: ;
			endcase
		end
	end
endmodule

[design/pet_sqrt.sv]
// Iterative integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps

module pet_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pet_pkg::SUM_W-1:0]   radicand,
	output logic                        done,
	output logic [pet_pkg::ROOT_W-1:0]  root
);
	import pet_pkg::*;

	localparam logic [SUM_W-1:0] BIT_INIT = SUM_W'(1) << (SUM_W - 2);

	logic [SUM_W-1:0] v_q;
	logic [SUM_W-1:0] bit_q;
	logic [SUM_W:0]   res_q;
	logic [SUM_W:0]   trial;
	logic             fits;
	logic             running_q;
	logic             done_q;

	assign trial = res_q + {1'b0, bit_q};
	assign fits  = {1'b0, v_q} >= trial;
	assign done  = done_q;
	assign root  = res_q[ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				running_q <= 1'b1;
			end else if (running_q && bit_q[0]) begin
				running_q <= 1'b0;
				done_q    <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			res_q <= '0;
			bit_q <= BIT_INIT;
		end else if (running_q) begin
			if (fits) begin
				v_q   <= v_q - trial[SUM_W-1:0];
				res_q <= (res_q >> 1) + {1'b0, bit_q};
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule

[design/periodic_event_trigger.sv]
// Periodic event trigger: norm-based transmit decision with a forced-refresh rule.
// The datapath is one shared 17x17 multiplier (two products per element) and one shared
// square root unit that runs 17 steps for each of the two norms.
// One item at a time; the next sample is accepted the cycle after the result is registered.
// Reset: registers to defaults, stored vector, skip count, counters and energy cleared.
`timescale 1ns / 1ps

module periodic_event_trigger #(
	parameter int MAX_DIM = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	pet_sample_if.sink   samples,
	pet_result_if.source results,
	pet_cfg_if.sink      cfg
);
	import pet_pkg::*;

	localparam int LAST_DEPTH = (MAX_DIM < NUM_IN) ? MAX_DIM : NUM_IN;
	localparam int IDX_W      = (LAST_DEPTH > 1) ? $clog2(LAST_DEPTH) : 1;

	cfg_regs_t regs;

	pet_state_t state_q, state_d;

	logic [IDX_W-1:0]           elem_q;
	logic [DIM_W-1:0]           n_q;
	logic [DIM_W-1:0]           n_eff;
	logic signed [SAMPLE_W-1:0] sample_in [NUM_IN];
	logic signed [SAMPLE_W-1:0] samp_q [LAST_DEPTH];
	logic signed [SAMPLE_W-1:0] last_q [LAST_DEPTH];
	logic [SUM_W-1:0]           esum_q;
	logic [SUM_W-1:0]           xsum_q;
	logic [ROOT_W-1:0]          en_q;
	logic [ROOT_W-1:0]          xn_q;
	logic [PROD_W-1:0]          prod_q;
	logic [SKIP_W-1:0]          skip_q;
	logic [CNT_W-1:0]           samp_cnt_q;
	logic [CNT_W-1:0]           evt_cnt_q;
	logic [ENERGY_W-1:0]        energy_q;

	logic                out_valid_q;
	logic                out_transmit_q;
	logic                out_forced_q;
	logic [ROOT_W-1:0]   out_en_q;
	logic [ROOT_W-1:0]   out_xn_q;
	logic [SKIP_W-1:0]   out_skips_q;
	logic [CNT_W-1:0]    out_samp_q;
	logic [CNT_W-1:0]    out_evt_q;
	logic [ENERGY_W-1:0] out_energy_q;

	logic                       in_acc;
	logic                       out_free;
	logic                       commit;
	logic                       elem_last;
	logic signed [SAMPLE_W-1:0] cur_x;
	logic signed [SAMPLE_W-1:0] cur_l;
	logic signed [MAG_W-1:0]    diff;
	logic signed [MAG_W-1:0]    x_ext;
	logic [MAG_W-1:0]           mag_e;
	logic [MAG_W-1:0]           mag_x;
	logic [MAG_W-1:0]           mul_a;
	logic [MAG_W-1:0]           mul_b;
	logic [SUM_W-1:0]           product;
	logic [SUM_W-1:0]           lhs;
	logic [SUM_W-1:0]           rhs;
	logic                       forced;
	logic                       trig;
	logic [ENERGY_W:0]          energy_sum;
	logic [ENERGY_W-1:0]        energy_next;
	logic [SKIP_W-1:0]          skip_next;
	logic                       sq_start;
	logic [SUM_W-1:0]           sq_rad;
	logic                       sq_done;
	logic [ROOT_W-1:0]          sq_root;

	pet_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	pet_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_rad),
		.done     (sq_done),
		.root     (sq_root)
	);

	assign sample_in[0] = samples.sample_0;
	assign sample_in[1] = samples.sample_1;
	assign sample_in[2] = samples.sample_2;
	assign sample_in[3] = samples.sample_3;

	assign samples.ready = (state_q == ST_IDLE);
	assign in_acc        = samples.valid && samples.ready;
	assign out_free      = !out_valid_q || results.ready;
	assign commit        = (state_q == ST_DECIDE) && out_free;

	assign n_eff = (regs.dimension > DIM_W'(LAST_DEPTH)) ? DIM_W'(LAST_DEPTH) : regs.dimension;
	assign elem_last = (DIM_W'(elem_q) + DIM_W'(1)) == n_q;

	// element operands: error magnitude and state magnitude
	assign cur_x = samp_q[elem_q];
	assign cur_l = last_q[elem_q];
	assign diff  = {cur_l[SAMPLE_W-1], cur_l} - {cur_x[SAMPLE_W-1], cur_x};
	assign x_ext = {cur_x[SAMPLE_W-1], cur_x};
	assign mag_e = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
	assign mag_x = x_ext[MAG_W-1] ? MAG_W'(-x_ext) : MAG_W'(x_ext);

	// the one multiplier: squares during accumulation, sigma * state_norm afterwards
	always_comb begin
		case (state_q)
			ST_ACC_E: begin
				mul_a = mag_e;
				mul_b = mag_e;
			end
			ST_ACC_X: begin
				mul_a = mag_x;
				mul_b = mag_x;
			end
			default: begin
				mul_a = MAG_W'(regs.sigma);
				mul_b = MAG_W'(xn_q);
			end
		endcase
	end
	assign product = mul_a * mul_b;

	// exact test: en * 2^16 > sigma * xn + eps * 2^16
	assign lhs    = SUM_W'({en_q, {GAIN_W{1'b0}}});
	assign rhs    = SUM_W'(prod_q) + SUM_W'({regs.epsilon, {GAIN_W{1'b0}}});
	assign forced = skip_q >= regs.skip_limit;
	assign trig   = forced || (lhs > rhs);

	// saturating once over both costs gives the same total as two saturating adds
	assign energy_sum = {1'b0, energy_q} + (ENERGY_W + 1)'(regs.tick_cost)
		+ (trig ? (ENERGY_W + 1)'(regs.send_cost) : '0);
	assign energy_next = energy_sum[ENERGY_W] ? '1 : energy_sum[ENERGY_W-1:0];
	assign skip_next = trig ? '0 : ((skip_q != '1) ? skip_q + SKIP_W'(1) : skip_q);

	assign sq_rad = (state_q == ST_SQ_E) ? xsum_q : ((state_q == ST_IDLE) ? '0 : esum_q);

	always_comb begin
		state_d  = state_q;
		sq_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (n_eff == '0) begin
						state_d  = ST_SQ_E;
						sq_start = 1'b1;
					end else begin
						state_d = ST_ACC_E;
					end
				end
			end
			ST_ACC_E: state_d = ST_ACC_X;
			ST_ACC_X: begin
				if (elem_last) begin
					state_d  = ST_SQ_E;
					sq_start = 1'b1;
				end else begin
					state_d = ST_ACC_E;
				end
			end
			ST_SQ_E: begin
				if (sq_done) begin
					state_d  = ST_SQ_X;
					sq_start = 1'b1;
				end
			end
			ST_SQ_X: begin
				if (sq_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_q      <= '0;
			n_q         <= '0;
			skip_q      <= '0;
			samp_cnt_q  <= '0;
			evt_cnt_q   <= '0;
			energy_q    <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < LAST_DEPTH; i++) begin
				last_q[i] <= '0;
			end
		end else begin
			if (in_acc) begin
				elem_q <= '0;
				n_q    <= n_eff;
			end else if (state_q == ST_ACC_X) begin
				elem_q <= elem_q + IDX_W'(1);
			end

			if (commit) begin
				skip_q      <= skip_next;
				samp_cnt_q  <= samp_cnt_q + CNT_W'(1);
				evt_cnt_q   <= trig ? evt_cnt_q + CNT_W'(1) : evt_cnt_q;
				energy_q    <= energy_next;
				out_valid_q <= 1'b1;
				for (int i = 0; i < LAST_DEPTH; i++) begin
					if (trig && (DIM_W'(i) < n_q)) begin
						last_q[i] <= samp_q[i];
					end
				end
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					esum_q <= '0;
					xsum_q <= '0;
					for (int i = 0; i < LAST_DEPTH; i++) begin
						samp_q[i] <= sample_in[i];
					end
				end
			end
			ST_ACC_E: esum_q <= esum_q + product;
			ST_ACC_X: xsum_q <= xsum_q + product;
			ST_SQ_E: begin
				if (sq_done) begin
					en_q <= sq_root;
				end
			end
			ST_SQ_X: begin
				if (sq_done) begin
					xn_q <= sq_root;
				end
			end
			ST_MUL: prod_q <= product[PROD_W-1:0];
			default: ;
		endcase

		if (commit) begin
			out_transmit_q <= trig;
			out_forced_q   <= forced;
			out_en_q       <= en_q;
			out_xn_q       <= xn_q;
			out_skips_q    <= skip_next;
			out_samp_q     <= samp_cnt_q + CNT_W'(1);
			out_evt_q      <= trig ? evt_cnt_q + CNT_W'(1) : evt_cnt_q;
			out_energy_q   <= energy_next;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.transmit     = out_transmit_q;
	assign results.forced       = out_forced_q;
	assign results.error_norm   = ENORM_W'(out_en_q);
	assign results.state_norm   = SNORM_W'(out_xn_q);
	assign results.skips        = out_skips_q;
	assign results.samples_seen = out_samp_q;
	assign results.events_sent  = out_evt_q;
	assign results.energy_used  = out_energy_q;

	a_transmit_clears_skips: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_transmit_q |-> out_skips_q == '0)
		else $error("transmit result with nonzero skip count");

	a_forced_is_transmit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_forced_q |-> out_transmit_q)
		else $error("forced result without transmit");

	a_sqrt_done_in_root_state: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> (state_q == ST_SQ_E || state_q == ST_SQ_X))
		else $error("square root finished outside a root state");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != ST_IDLE)
		else $error("sequencer stayed idle after accepting an item");

	a_commit_counts_sample: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q && (samp_cnt_q == $past(samp_cnt_q) + CNT_W'(1)))
		else $error("sample counter did not advance on result");
endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the periodic event trigger: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;
	import pet_pkg::*;

	localparam int MAX_DIM       = 4;
	localparam int DIR_N         = 35;
	localparam int RAND_ITEMS    = 1300;
	localparam int SETTLE_CYCLES = 60;
	localparam int TAIL_CYCLES   = 60;
	localparam int STALL_LIMIT   = 3000;

	// indexes with no register behind them; writes there must do nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

	typedef logic [NUM_IN-1:0][SAMPLE_W-1:0] state_vec_t;

	typedef struct packed {
		logic                transmit;
		logic                forced;
		logic [ENORM_W-1:0]  error_norm;
		logic [SNORM_W-1:0]  state_norm;
		logic [SKIP_W-1:0]   skips;
		logic [CNT_W-1:0]    samples_seen;
		logic [CNT_W-1:0]    events_sent;
		logic [ENERGY_W-1:0] energy_used;
	} trig_result_t;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_SAMPLE,
		ROW_CHECKED
	} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		state_vec_t            vec;
		trig_result_t          want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	pet_sample_if samp_ch ();
	pet_result_if res_ch ();
	pet_cfg_if    cfg_ch ();

	periodic_event_trigger #(
		.MAX_DIM(MAX_DIM)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samp_ch),
		.results(res_ch),
		.cfg    (cfg_ch)
	);

	// predictor copy of the registers
	logic [DIM_W-1:0]  cur_dim        = DIMENSION_RST;
	logic [GAIN_W-1:0] cur_sigma      = SIGMA_RST;
	logic [EPS_W-1:0]  cur_eps        = EPSILON_RST;
	logic [SKIP_W-1:0] cur_skip_limit = SKIP_LIMIT_RST;
	logic [COST_W-1:0] cur_tick_cost  = TICK_COST_RST;
	logic [COST_W-1:0] cur_send_cost  = SEND_COST_RST;

	// predictor copy of the state
	logic signed [SAMPLE_W-1:0] sent_vec [MAX_DIM] = '{default: '0};
	logic [SKIP_W-1:0]          skip_run     = '0;
	logic [CNT_W-1:0]           sample_total = '0;
	logic [CNT_W-1:0]           event_total  = '0;
	logic [ENERGY_W-1:0]        energy_acc   = '0;

	trig_result_t pending_results [$];
	dir_row_t     dir_tab [DIR_N];
	int           errors     = 0;
	int           result_cnt = 0;
	int           res_hold   = 0;
	bit           no_idle    = 1'b0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic int draw_wait();
		return no_idle ? 0 : $urandom_range(0, 11);
	endfunction

	function automatic logic [15:0] draw_field(input logic [15:0] top);
		case ($urandom_range(0, 3))
			0: return '0;
			1: return top;
			default: return 16'($urandom_range(0, int'(top)));
		endcase
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] place;
		root  = '0;
		place = 64'd1 << 62;
		while (place > v)
			place = place >> 2;
		while (place != 0) begin
			if (v >= root + place) begin
				v    = v - (root + place);
				root = (root >> 1) + place;
			end else begin
				root = root >> 1;
			end
			place = place >> 2;
		end
		return root;
	endfunction

	function automatic void add_energy(input logic [COST_W-1:0] cost);
		logic [ENERGY_W:0] sum;
		sum = {1'b0, energy_acc} + cost;
		energy_acc = sum[ENERGY_W] ? '1 : sum[ENERGY_W-1:0];
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_DIMENSION:  cur_dim        = data[DIM_W-1:0];
			REG_SIGMA:      cur_sigma      = data[GAIN_W-1:0];
			REG_EPSILON:    cur_eps        = data[EPS_W-1:0];
			REG_SKIP_LIMIT: cur_skip_limit = data[SKIP_W-1:0];
			REG_TICK_COST:  cur_tick_cost  = data[COST_W-1:0];
			REG_SEND_COST:  cur_send_cost  = data[COST_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic trig_result_t predict_trigger(input state_vec_t vec);
		trig_result_t r;
		int           n;
		longint       d;
		longint       x;
		logic [63:0]  esum;
		logic [63:0]  xsum;
		logic [63:0]  en;
		logic [63:0]  xn;
		logic [63:0]  lhs;
		logic [63:0]  rhs;
		bit           fire;
		bit           forced_now;
		n = int'(cur_dim);
		if (n > MAX_DIM)
			n = MAX_DIM;
		if (n > NUM_IN)
			n = NUM_IN;
		sample_total = sample_total + 1'b1;
		add_energy(cur_tick_cost);
		esum = '0;
		xsum = '0;
		for (int i = 0; i < n; i++) begin
			x    = longint'($signed(vec[i]));
			d    = longint'(sent_vec[i]) - x;
			esum = esum + 64'(d * d);
			xsum = xsum + 64'(x * x);
		end
		en  = int_sqrt(esum);
		xn  = int_sqrt(xsum);
		lhs = en << 16;
		rhs = 64'(cur_sigma) * xn + (64'(cur_eps) << 16);
		fire       = lhs > rhs;
		forced_now = skip_run >= cur_skip_limit;
		if (forced_now)
			fire = 1'b1;
		if (fire) begin
			event_total = event_total + 1'b1;
			add_energy(cur_send_cost);
			skip_run = '0;
			for (int i = 0; i < n; i++)
				sent_vec[i] = $signed(vec[i]);
		end else if (skip_run != '1) begin
			skip_run = skip_run + 1'b1;
		end
		r.transmit     = fire;
		r.forced       = forced_now;
		r.error_norm   = en[ENORM_W-1:0];
		r.state_norm   = xn[SNORM_W-1:0];
		r.skips        = skip_run;
		r.samples_seen = sample_total;
		r.events_sent  = event_total;
		r.energy_used  = energy_acc;
		return r;
	endfunction

	function automatic string show(input trig_result_t r);
		return $sformatf("tx=%0d forced=%0d err=%0d state=%0d skips=%0d %s%0d %s%0d %s%0d",
			r.transmit, r.forced, r.error_norm, r.state_norm, r.skips,
			"samples=", r.samples_seen, "events=", r.events_sent,
			"energy=", r.energy_used);
	endfunction

	function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		dir_row_t row;
		row      = '0;
		row.kind = ROW_CFG;
		row.idx  = idx;
		row.data = data;
		return row;
	endfunction

	function automatic dir_row_t smp_row(input logic [15:0] s0, input logic [15:0] s1,
			input logic [15:0] s2, input logic [15:0] s3);
		dir_row_t row;
		row        = '0;
		row.kind   = ROW_SAMPLE;
		row.vec[0] = s0;
		row.vec[1] = s1;
		row.vec[2] = s2;
		row.vec[3] = s3;
		return row;
	endfunction

	function automatic dir_row_t chk_row(input logic [15:0] s0, input logic [15:0] s1,
			input logic [15:0] s2, input logic [15:0] s3, input trig_result_t want);
		dir_row_t row;
		row      = smp_row(s0, s1, s2, s3);
		row.kind = ROW_CHECKED;
		row.want = want;
		return row;
	endfunction

	// valid stays high into the next item when the drawn wait is zero
	task automatic push_sample(input state_vec_t vec, input bit typed, input trig_result_t want);
		int           gap;
		trig_result_t r;
		gap = draw_wait();
		@(negedge clk);
		if (gap > 0) begin
			samp_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		samp_ch.valid    <= 1'b1;
		samp_ch.sample_0 <= vec[0];
		samp_ch.sample_1 <= vec[1];
		samp_ch.sample_2 <= vec[2];
		samp_ch.sample_3 <= vec[3];
		do @(posedge clk); while (!samp_ch.ready);
		r = predict_trigger(vec);
		pending_results.push_back(typed ? want : r);
	endtask

	// registers change only with the block idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		samp_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		apply_reg(idx, data);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (res_hold > 0) begin
			res_ch.ready <= 1'b0;
			res_hold = res_hold - 1;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		trig_result_t got;
		trig_result_t want;
		if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			got.transmit     = res_ch.transmit;
			got.forced       = res_ch.forced;
			got.error_norm   = res_ch.error_norm;
			got.state_norm   = res_ch.state_norm;
			got.skips        = res_ch.skips;
			got.samples_seen = res_ch.samples_seen;
			got.events_sent  = res_ch.events_sent;
			got.energy_used  = res_ch.energy_used;
			result_cnt = result_cnt + 1;
			if (pending_results.size() == 0) begin
				errors = errors + 1;
				if (errors <= 10)
					$display("result %0d with no item pending: %s", result_cnt, show(got));
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					errors = errors + 1;
					if (errors <= 10) begin
						$display("result %0d mismatch", result_cnt);
						$display("  expected %s", show(want));
						$display("  actual   %s", show(got));
					end
				end
			end
			res_hold = draw_wait();
		end
	end

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((samp_ch.valid === 1'b1 && samp_ch.ready === 1'b1)
					|| (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
					|| (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
				quiet_cycles = 0;
			else
				quiet_cycles = quiet_cycles + 1;
		end
		$display("periodic_event_trigger regression: fail");
		$finish;
	end

	initial begin : stimulus
		state_vec_t walk;
		int         sent;
		int         phase_len;
		int         mode;
		int         span;
		arst_n           = 1'b0;
		samp_ch.valid    = 1'b0;
		samp_ch.sample_0 = '0;
		samp_ch.sample_1 = '0;
		samp_ch.sample_2 = '0;
		samp_ch.sample_3 = '0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = '0;
		cfg_ch.data      = '0;
		walk             = '0;

		dir_tab = '{
			// fresh reset: zero vector stays under epsilon, then a unit step fires
			chk_row(16'h0000, 16'h0000, 16'h0000, 16'h0000,
				'{1'b0, 1'b0, 19'd0, 17'd0, 16'd1, 32'd1, 32'd0, 48'd410}),
			chk_row(16'h1000, 16'h0000, 16'h0000, 16'h0000,
				'{1'b1, 1'b0, 19'd4096, 17'd4096, 16'd0, 32'd2, 32'd1, 48'd4916}),
			smp_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF),
			smp_row(16'h8000, 16'h8000, 16'h8000, 16'h8000),
			smp_row(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF),
			// no elements in use: only the skip limit can fire
			cfg_row(REG_DIMENSION, 16'h0000),
			cfg_row(REG_SKIP_LIMIT, 16'd2),
			smp_row(16'h1234, 16'hEDCC, 16'h7FFF, 16'h8000),
			smp_row(16'h4000, 16'hC000, 16'h0001, 16'hFFFF),
			smp_row(16'h0FFF, 16'hF001, 16'h2000, 16'hE000),
			// all bits set in the dimension write, above the element count
			cfg_row(REG_DIMENSION, 16'hFFFF),
			cfg_row(REG_SKIP_LIMIT, 16'd0),
			smp_row(16'd1000, -16'sd2000, 16'd3000, -16'sd4000),
			// one element, threshold at its top: trailing elements must be kept
			cfg_row(REG_DIMENSION, 16'd1),
			cfg_row(REG_SKIP_LIMIT, 16'hFFFF),
			cfg_row(REG_SIGMA, 16'hFFFF),
			cfg_row(REG_EPSILON, 16'hFFFF),
			smp_row(16'h8000, 16'd5, 16'd6, 16'd7),
			smp_row(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
			// zero threshold: any error fires, equal vectors do not
			cfg_row(REG_SIGMA, 16'h0000),
			cfg_row(REG_EPSILON, 16'h0000),
			smp_row(16'h7FFF, 16'h0000, 16'h0000, 16'h0000),
			smp_row(16'h7FFF, 16'd1, 16'd2, 16'd3),
			cfg_row(REG_DIMENSION, 16'd2),
			cfg_row(REG_TICK_COST, 16'hFFFF),
			cfg_row(REG_SEND_COST, 16'hFFFF),
			cfg_row(REG_UNMAPPED_LO, 16'h0001),
			cfg_row(REG_UNMAPPED_HI, 16'hFFFF),
			smp_row(16'd1, 16'hFFFF, 16'h0000, 16'h0000),
			smp_row(16'hFFFF, 16'd1, 16'h0000, 16'h0000),
			cfg_row(REG_DIMENSION, 16'd3),
			cfg_row(REG_TICK_COST, 16'h0000),
			cfg_row(REG_SEND_COST, 16'h0000),
			smp_row(16'h8000, 16'h8000, 16'h7FFF, 16'h0000),
			smp_row(16'h0000, 16'h0000, 16'h0000, 16'h0000)
		};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[k]) begin
			case (dir_tab[k].kind)
				ROW_CFG:     write_reg(dir_tab[k].idx, dir_tab[k].data);
				ROW_CHECKED: push_sample(dir_tab[k].vec, 1'b1, dir_tab[k].want);
				default:     push_sample(dir_tab[k].vec, 1'b0, '0);
			endcase
		end

		sent = 0;
		while (sent < RAND_ITEMS) begin
			phase_len = $urandom_range(40, 160);
			if (phase_len > RAND_ITEMS - sent)
				phase_len = RAND_ITEMS - sent;
			no_idle   = ($urandom_range(0, 3) == 0);
			write_reg(REG_DIMENSION, 16'($urandom_range(0, 65535)));
			write_reg(REG_SIGMA, draw_field(16'hFFFF));
			write_reg(REG_EPSILON, draw_field(16'h7FFF) | (16'($urandom_range(0, 1)) << 15));
			write_reg(REG_SKIP_LIMIT, ($urandom_range(0, 3) == 0)
				? draw_field(16'hFFFF) : 16'($urandom_range(0, 24)));
			write_reg(REG_TICK_COST, draw_field(16'hFFFF));
			write_reg(REG_SEND_COST, draw_field(16'hFFFF));
			if ($urandom_range(0, 2) == 0)
				write_reg($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
					16'($urandom_range(0, 65535)));
			repeat (phase_len) begin
				// mostly a slow drift so the skip and forced paths get exercised
				mode = $urandom_range(0, 9);
				for (int i = 0; i < NUM_IN; i++) begin
					if (mode < 7) begin
						span    = 1 << $urandom_range(0, 12);
						walk[i] = walk[i] + 16'($urandom_range(0, 2 * span)) - 16'(span);
					end else if (mode < 9) begin
						walk[i] = 16'($urandom_range(0, 65535));
					end else begin
						case ($urandom_range(0, 3))
							0: walk[i] = 16'h8000;
							1: walk[i] = 16'h7FFF;
							2: walk[i] = 16'h0000;
							default: walk[i] = 16'hFFFF;
						endcase
					end
				end
				push_sample(walk, 1'b0, '0);
				sent = sent + 1;
			end
		end

		@(negedge clk);
		samp_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("periodic_event_trigger regression: pass");
		else
			$display("periodic_event_trigger regression: fail");
		$finish;
	end

endmodule

[sim.f]
design/pet_pkg.sv
design/pet_sample_if.sv
design/pet_result_if.sv
design/pet_cfg_if.sv
design/pet_cfg.sv
design/pet_sqrt.sv
design/periodic_event_trigger.sv
tb/sv/tb_top.sv
